FILE: rtl/core/point_in_polygon_test_macros.svh
// Assertion macros shared by the point-in-polygon tester.
// Each property is clocked on clk_i and is held off while rst_ni is low.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_in_polygon_test: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_in_polygon_test: next-cycle check failed");

`else

`define PIP_ASSERT_NOW(label, ante, cons)
`define PIP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/pip_pkg.sv
package pip_pkg;

  // Widths of the request fields on the ports.
  localparam int ReqW   = 2;
  localparam int FieldW = 16;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [ReqW-1:0] REQ_APPEND = 2'd1;
  localparam logic [ReqW-1:0] REQ_TEST   = 2'd2;
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  // A test on a polygon with fewer than this many vertices reports too few vertices.
  localparam int MinVertices = 2;

  // Control bits that travel with every request that enters the cell row.
  typedef struct packed {
    logic valid;    // slot holds a request
    logic is_test;  // 1: test point, 0: append vertex
    logic few;      // polygon had too few vertices when the test was accepted
    logic ovf;      // overflow flag sampled when the test was accepted
    logic parity;   // running crossing parity
  } pip_ctrl_t;

endpackage

FILE: rtl/core/point_in_polygon_test.sv
// Point-in-polygon tester, crossing-number rule, one cell per polygon edge.
// A test result passes the row of cells, two register stages each, then the result register.
// The row is the pipe: one request per cycle, while the result register is free or drained.
// A stalled result freezes the whole row, so the pipe never drops or reorders requests.
// Reset clears the vertex count, the overflow flag and all valid bits; vertex registers are not
// cleared and are only read below the vertex count.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pip_pkg::ReqW-1:0]              req_type_i,
  input  logic signed [pip_pkg::FieldW-1:0]     coord_x_i,
  input  logic signed [pip_pkg::FieldW-1:0]     coord_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  inside_res_o,
  output logic                                  too_few_vertices_o,
  output logic                                  overflowed_o
);

  // Coordinates wrap to COORD_BITS when that is narrower than the port fields.
  localparam int CW   = (COORD_BITS < pip_pkg::FieldW) ? COORD_BITS : pip_pkg::FieldW;
  // The count must be able to hold MAX_VERTICES itself.
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  // Polygon bookkeeping. These are updated as soon as a request is accepted; every
  // append that fits then travels down the row and lands in the cells that hold its edges,
  // always behind earlier tests and ahead of later ones.
  logic [CNTW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic accept, en, room;
  logic acc_clear, acc_append;

  // The row: slot k feeds cell k, slot MAX_VERTICES is the row's output.
  pip_pkg::pip_ctrl_t   ctrl_c [MAX_VERTICES+1];
  logic signed [CW-1:0] x_c    [MAX_VERTICES+1];
  logic signed [CW-1:0] y_c    [MAX_VERTICES+1];
  logic [CNTW-1:0]      n_c    [MAX_VERTICES+1];

  // Result register that separates the row from the downstream consumer.
  logic out_valid_q, out_valid_d;
  logic inside_q, few_q, res_ovf_q;

  // The row advances whenever the result register is free or being drained.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign room       = count_q < CNTW'(MAX_VERTICES);
  assign acc_clear  = accept && (req_type_i == pip_pkg::REQ_CLEAR);
  assign acc_append = accept && (req_type_i == pip_pkg::REQ_APPEND);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      unique case (req_type_i)
        pip_pkg::REQ_CLEAR: begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        pip_pkg::REQ_APPEND: begin
          if (room) begin
            count_d = count_q + CNTW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        pip_pkg::REQ_TEST: begin
        end
        pip_pkg::REQ_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Only tests and appends that fit enter the row. A test carries the vertex count and
  // the overflow flag as they stood when it was accepted; an append carries its slot.
  always_comb begin
    ctrl_c[0].valid   = accept && ((req_type_i == pip_pkg::REQ_TEST) ||
                                   ((req_type_i == pip_pkg::REQ_APPEND) && room));
    ctrl_c[0].is_test = req_type_i == pip_pkg::REQ_TEST;
    ctrl_c[0].few     = count_q < CNTW'(pip_pkg::MinVertices);
    ctrl_c[0].ovf     = ovf_q;
    ctrl_c[0].parity  = 1'b0;
  end

  assign x_c[0] = coord_x_i[CW-1:0];
  assign y_c[0] = coord_y_i[CW-1:0];
  assign n_c[0] = count_q;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cells
    pip_cell #(
      .CW   (CW),
      .CNTW (CNTW),
      .INDEX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctrl_i(ctrl_c[g]),
      .x_i   (x_c[g]),
      .y_i   (y_c[g]),
      .n_i   (n_c[g]),
      .ctrl_o(ctrl_c[g+1]),
      .x_o   (x_c[g+1]),
      .y_o   (y_c[g+1]),
      .n_o   (n_c[g+1])
    );
  end

  // Appends leave the row silently; only tests produce a result.
  assign out_valid_d = en ? (ctrl_c[MAX_VERTICES].valid && ctrl_c[MAX_VERTICES].is_test)
                          : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q  <= ctrl_c[MAX_VERTICES].parity && !ctrl_c[MAX_VERTICES].few;
      few_q     <= ctrl_c[MAX_VERTICES].few;
      res_ovf_q <= ctrl_c[MAX_VERTICES].ovf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign inside_res_o       = inside_q;
  assign too_few_vertices_o = few_q;
  assign overflowed_o       = res_ovf_q;

  `include "point_in_polygon_test_macros.svh"

  // A clear empties the polygon and drops the overflow flag.
  `PIP_ASSERT_NEXT(a_clear_empties, acc_clear, (count_q == '0) && !ovf_q)
  // An append into a full polygon raises the overflow flag and leaves the count alone.
  `PIP_ASSERT_NEXT(a_full_append_flags, acc_append && !room, ovf_q && (count_q == $past(count_q)))
  // An append with room grows the count by exactly one.
  `PIP_ASSERT_NEXT(a_append_counts, acc_append && room, count_q == $past(count_q) + CNTW'(1))

endmodule

FILE: rtl/core/pip_cell.sv
// One edge of the polygon. The cell at position INDEX holds edge v[INDEX-1] -> v[INDEX];
// cell 0 holds the closing edge v[n-1] -> v[0]. Two register stages: products, then sign.
module pip_cell #(
  parameter int CW    = 16,
  parameter int CNTW  = 6,
  parameter int INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pip_pkg::pip_ctrl_t  ctrl_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic [CNTW-1:0]     n_i,
  output pip_pkg::pip_ctrl_t  ctrl_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [CNTW-1:0]     n_o
);

  localparam int PW = 2 * CW + 2;
  localparam int TW = 2 * CW + 3;

  // Edge endpoints, written by append requests as they pass.
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;

  logic is_append, wr_a, wr_b, active, straddle;
  logic signed [CW:0] dxp, dyab, dxab, dypb;
  logic signed [PW-1:0] p1_d, p2_d;

  pip_pkg::pip_ctrl_t ctrl1_q, ctrl1_d, ctrl2_q, ctrl2_d;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [CNTW-1:0] n1_q, n2_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic hit_q, hit_d, neg_q, neg_d;

  logic signed [TW-1:0] t;
  logic toggle;

  assign is_append = ctrl_i.valid && !ctrl_i.is_test;
  assign wr_b      = is_append && (n_i == CNTW'(INDEX));
  // Cell 0 always tracks the most recent vertex as the start of the closing edge.
  assign wr_a      = is_append && ((INDEX == 0) || (n_i == CNTW'(INDEX - 1)));

  assign active   = ctrl_i.valid && ctrl_i.is_test && !ctrl_i.few && (CNTW'(INDEX) < n_i);
  assign straddle = ((by_q <= y_i) && (y_i < ay_q)) || ((ay_q <= y_i) && (y_i < by_q));

  assign dxp  = {x_i[CW-1], x_i} - {bx_q[CW-1], bx_q};
  assign dyab = {ay_q[CW-1], ay_q} - {by_q[CW-1], by_q};
  assign dxab = {ax_q[CW-1], ax_q} - {bx_q[CW-1], bx_q};
  assign dypb = {y_i[CW-1], y_i} - {by_q[CW-1], by_q};

  assign p1_d  = dxp * dyab;
  assign p2_d  = dxab * dypb;
  assign hit_d = active && straddle;
  assign neg_d = ay_q < by_q;

  always_comb begin
    ctrl1_d = ctrl_i;
  end

  // Stage two: signed cross term; a negative normalized term flips the parity.
  assign t      = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
  assign toggle = hit_q && (neg_q ? (!t[TW-1] && (t != '0)) : t[TW-1]);

  always_comb begin
    ctrl2_d        = ctrl1_q;
    ctrl2_d.parity = ctrl1_q.parity ^ toggle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else if (en_i) begin
      ctrl1_q <= ctrl1_d;
      ctrl2_q <= ctrl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= x_i;
      y1_q  <= y_i;
      n1_q  <= n_i;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      hit_q <= hit_d;
      neg_q <= neg_d;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      n2_q  <= n1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_a) begin
      ax_q <= x_i;
      ay_q <= y_i;
    end
    if (en_i && wr_b) begin
      bx_q <= x_i;
      by_q <= y_i;
    end
  end

  assign ctrl_o = ctrl2_q;
  assign x_o    = x2_q;
  assign y_o    = y2_q;
  assign n_o    = n2_q;

endmodule
